@@ design/gdnd_pkg.sv @@
// ----------------------------------------------------------------------------
// gdnd_pkg
// Shared types, constants and lookup functions for the next-day date unit.
// ----------------------------------------------------------------------------
package gdnd_pkg;

  localparam int unsigned DATE_W  = 27;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned DIM_W   = 5;
  localparam int unsigned DIGIT_W = 7;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned Q100_W  = 21;
  localparam int unsigned YC_W    = 8;
  localparam int unsigned PACK_W  = 28;

  // floor(n / 100) for n < 2**27
  localparam logic [27:0] M100   = 28'd171798692;
  localparam int unsigned SH100  = 34;
  localparam int unsigned P100_W = DATE_W + 28;
  // floor(n / 10000) for n < 2**27
  localparam logic [26:0] M10K   = 27'd109951163;
  localparam int unsigned SH10K  = 40;
  localparam int unsigned P10K_W = DATE_W + 27;
  // floor(y / 100) for y < 2**14
  localparam logic [14:0] MY     = 15'd20972;
  localparam int unsigned SHY    = 21;
  localparam int unsigned PY_W   = YEAR_W + 15;

  localparam logic [DATE_W-1:0] NEXT_DATE_MAX = 27'd99991231;
  localparam logic [PACK_W-1:0] YEAR_LIMIT    = 28'd100000000;

  localparam logic [DIGIT_W-1:0] MONTH_JAN = 7'd1;
  localparam logic [DIGIT_W-1:0] MONTH_FEB = 7'd2;
  localparam logic [DIGIT_W-1:0] MONTH_DEC = 7'd12;
  localparam logic [IDX_W-1:0]   IDX_MAR   = 4'd2;
  localparam logic [IDX_W-1:0]   IDX_LAST  = 4'd12;

  typedef struct packed {
    logic [DATE_W-1:0] date;
    logic [DATE_W-1:0] other_date;
  } request_t;

  typedef struct packed {
    logic [DATE_W-1:0]  next_date;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
    logic [DOY_W-1:0]   day_of_year;
    logic [DIM_W-1:0]   days_in_month;
    logic               leap_year;
    logic               is_earlier;
    logic               year_overflow;
  } result_t;

  function automatic logic [DOY_W-1:0] prior_days(input logic [IDX_W-1:0] idx);
    logic [DOY_W-1:0] r;
    unique case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      4'd12:   r = 9'd365;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] month_length(input logic [DIGIT_W-1:0] m,
                                                   input logic leap);
    logic [DIM_W-1:0] r;
    unique case (m)
      7'd4, 7'd6, 7'd9, 7'd11:                   r = 5'd30;
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: r = 5'd31;
      MONTH_FEB:                                 r = leap ? 5'd29 : 5'd28;
      default:                                   r = 5'd28;
    endcase
    return r;
  endfunction

endpackage

@@ design/gdnd_request_if.sv @@
// ----------------------------------------------------------------------------
// gdnd_request_if
// Valid/ready channel carrying a pair of packed dates.
// ----------------------------------------------------------------------------
interface gdnd_request_if;
  logic               valid;
  logic               ready;
  gdnd_pkg::request_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/gdnd_result_if.sv @@
// ----------------------------------------------------------------------------
// gdnd_result_if
// Valid/ready channel carrying one next-day result.
// ----------------------------------------------------------------------------
interface gdnd_result_if;
  logic              valid;
  logic              ready;
  gdnd_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/gdnd_repack.sv @@
// ----------------------------------------------------------------------------
// gdnd_repack
// Recombine year, month and day into yyyymmdd, saturate at year 10000.
// ----------------------------------------------------------------------------
module gdnd_repack (
  input  logic [gdnd_pkg::YEAR_W-1:0]  year,
  input  logic [gdnd_pkg::DIGIT_W-1:0] month,
  input  logic [gdnd_pkg::DIGIT_W-1:0] day,
  output logic [gdnd_pkg::DATE_W-1:0]  packed_date,
  output logic                         overflow
);

  logic [gdnd_pkg::PACK_W-1:0] sum;

  always_comb begin
    sum = gdnd_pkg::PACK_W'(year) * gdnd_pkg::PACK_W'(10000)
        + gdnd_pkg::PACK_W'(month) * gdnd_pkg::PACK_W'(100)
        + gdnd_pkg::PACK_W'(day);
    overflow = (sum >= gdnd_pkg::YEAR_LIMIT);
    packed_date = overflow ? gdnd_pkg::NEXT_DATE_MAX : sum[gdnd_pkg::DATE_W-1:0];
  end

endmodule

@@ design/gregorian_date_next_day.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_next_day
// Split a packed yyyymmdd date, report leap year, month length and day of
// year, and give the following day packed again.
//
//   channel   modport  payload    per transfer
//   request   sink     request_t  date, other_date
//   result    source   result_t   next_date and calendar fields
//
// Five register stages; one transfer per cycle unless the result side stalls.
// The reciprocal multiplies for /100 and /10000 set the stage depth.
// Reset clears the stage valid bits only.
// A stalled result holds its stage; bubbles ahead of it still fill.
// ----------------------------------------------------------------------------
module gregorian_date_next_day (
  input  logic                 clk,
  input  logic                 rst,
  gdnd_request_if.sink         request,
  gdnd_result_if.source        result
);

  logic adv1, adv2, adv3, adv4, adv5;

  // stage 1
  logic                           s1_valid;
  logic [gdnd_pkg::DATE_W-1:0]    s1_date;
  logic                           s1_earlier;
  logic [gdnd_pkg::P100_W-1:0]    s1_p100;
  logic [gdnd_pkg::P10K_W-1:0]    s1_p10k;

  // stage 2
  logic                           s2_valid;
  logic [gdnd_pkg::YEAR_W-1:0]    s2_year;
  logic [gdnd_pkg::DIGIT_W-1:0]   s2_month;
  logic [gdnd_pkg::DIGIT_W-1:0]   s2_day;
  logic [gdnd_pkg::PY_W-1:0]      s2_py;
  logic                           s2_earlier;
  logic [gdnd_pkg::Q100_W-1:0]    q100;
  logic [gdnd_pkg::YEAR_W-1:0]    year_q;
  logic [gdnd_pkg::DATE_W-1:0]    day_rem;
  logic [gdnd_pkg::Q100_W-1:0]    month_rem;

  // stage 3
  logic                           s3_valid;
  logic [gdnd_pkg::YEAR_W-1:0]    s3_year;
  logic [gdnd_pkg::DIGIT_W-1:0]   s3_month;
  logic [gdnd_pkg::DIGIT_W-1:0]   s3_day;
  logic                           s3_leap;
  logic                           s3_earlier;
  logic [gdnd_pkg::YC_W-1:0]      cent;
  logic [gdnd_pkg::YEAR_W-1:0]    cent_rem;
  logic                           leap_next;

  // stage 4
  logic                           s4_valid;
  logic [gdnd_pkg::YEAR_W-1:0]    s4_year;
  logic [gdnd_pkg::DIGIT_W-1:0]   s4_month;
  logic [gdnd_pkg::DIGIT_W-1:0]   s4_day;
  logic [gdnd_pkg::DOY_W-1:0]     s4_doy;
  logic [gdnd_pkg::DIM_W-1:0]     s4_dim;
  logic                           s4_leap;
  logic                           s4_earlier;
  logic [gdnd_pkg::YEAR_W-1:0]    s4_ny;
  logic [gdnd_pkg::DIGIT_W-1:0]   s4_nm;
  logic [gdnd_pkg::DIGIT_W-1:0]   s4_nd;
  logic [gdnd_pkg::IDX_W-1:0]     idx;
  logic [gdnd_pkg::DIM_W-1:0]     dim_next;
  logic [gdnd_pkg::DOY_W-1:0]     doy_next;
  logic [gdnd_pkg::YEAR_W-1:0]    ny_next;
  logic [gdnd_pkg::DIGIT_W-1:0]   nm_next;
  logic [gdnd_pkg::DIGIT_W-1:0]   nd_next;

  // stage 5
  logic                           res_valid;
  gdnd_pkg::result_t              res;
  logic [gdnd_pkg::DATE_W-1:0]    packed_next;
  logic                           overflow_next;

  assign adv5 = !res_valid || result.ready;
  assign adv4 = !s4_valid || adv5;
  assign adv3 = !s3_valid || adv4;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;

  assign request.ready  = adv1;
  assign result.valid   = res_valid;
  assign result.payload = res;

  // stage 1: reciprocal products, ordering compare
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= request.valid;
    end
    if (adv1) begin
      s1_date    <= request.payload.date;
      s1_earlier <= (request.payload.date < request.payload.other_date);
      s1_p100    <= gdnd_pkg::P100_W'(request.payload.date)
                  * gdnd_pkg::P100_W'(gdnd_pkg::M100);
      s1_p10k    <= gdnd_pkg::P10K_W'(request.payload.date)
                  * gdnd_pkg::P10K_W'(gdnd_pkg::M10K);
    end
  end

  // stage 2: quotients and digit pairs, century product
  always_comb begin
    q100      = s1_p100[gdnd_pkg::SH100 +: gdnd_pkg::Q100_W];
    year_q    = s1_p10k[gdnd_pkg::SH10K +: gdnd_pkg::YEAR_W];
    day_rem   = s1_date - gdnd_pkg::DATE_W'(q100) * gdnd_pkg::DATE_W'(100);
    month_rem = q100 - gdnd_pkg::Q100_W'(year_q) * gdnd_pkg::Q100_W'(100);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
    if (adv2) begin
      s2_year    <= year_q;
      s2_month   <= month_rem[gdnd_pkg::DIGIT_W-1:0];
      s2_day     <= day_rem[gdnd_pkg::DIGIT_W-1:0];
      s2_py      <= gdnd_pkg::PY_W'(year_q) * gdnd_pkg::PY_W'(gdnd_pkg::MY);
      s2_earlier <= s1_earlier;
    end
  end

  // stage 3: leap year
  always_comb begin
    cent      = s2_py[gdnd_pkg::SHY +: gdnd_pkg::YC_W];
    cent_rem  = s2_year - gdnd_pkg::YEAR_W'(cent) * gdnd_pkg::YEAR_W'(100);
    leap_next = (cent_rem == '0) ? (cent[1:0] == 2'b00) : (s2_year[1:0] == 2'b00);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
    if (adv3) begin
      s3_year    <= s2_year;
      s3_month   <= s2_month;
      s3_day     <= s2_day;
      s3_leap    <= leap_next;
      s3_earlier <= s2_earlier;
    end
  end

  // stage 4: month length, day of year, next day fields
  always_comb begin
    priority if (s3_month == '0) begin
      idx = '0;
    end else if (s3_month > gdnd_pkg::MONTH_DEC) begin
      idx = gdnd_pkg::IDX_LAST;
    end else begin
      idx = gdnd_pkg::IDX_W'(s3_month - gdnd_pkg::MONTH_JAN);
    end
    dim_next = gdnd_pkg::month_length(s3_month, s3_leap);
    doy_next = gdnd_pkg::prior_days(idx)
             + gdnd_pkg::DOY_W'(s3_leap && (idx >= gdnd_pkg::IDX_MAR))
             + gdnd_pkg::DOY_W'(s3_day);
    if (s3_day == gdnd_pkg::DIGIT_W'(dim_next)) begin
      nd_next = gdnd_pkg::DIGIT_W'(1);
      if (s3_month == gdnd_pkg::MONTH_DEC) begin
        nm_next = gdnd_pkg::MONTH_JAN;
        ny_next = s3_year + gdnd_pkg::YEAR_W'(1);
      end else begin
        nm_next = s3_month + gdnd_pkg::DIGIT_W'(1);
        ny_next = s3_year;
      end
    end else begin
      nd_next = s3_day + gdnd_pkg::DIGIT_W'(1);
      nm_next = s3_month;
      ny_next = s3_year;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv4) begin
      s4_valid <= s3_valid;
    end
    if (adv4) begin
      s4_year    <= s3_year;
      s4_month   <= s3_month;
      s4_day     <= s3_day;
      s4_doy     <= doy_next;
      s4_dim     <= dim_next;
      s4_leap    <= s3_leap;
      s4_earlier <= s3_earlier;
      s4_ny      <= ny_next;
      s4_nm      <= nm_next;
      s4_nd      <= nd_next;
    end
  end

  // stage 5: repack into the output register
  gdnd_repack u_repack (
    .year        (s4_ny),
    .month       (s4_nm),
    .day         (s4_nd),
    .packed_date (packed_next),
    .overflow    (overflow_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv5) begin
      res_valid <= s4_valid;
    end
    if (adv5) begin
      res.next_date     <= packed_next;
      res.year          <= s4_year;
      res.month         <= s4_month[gdnd_pkg::MONTH_W-1:0];
      res.day_of_month  <= s4_day[gdnd_pkg::DAY_W-1:0];
      res.day_of_year   <= s4_doy;
      res.days_in_month <= s4_dim;
      res.leap_year     <= s4_leap;
      res.is_earlier    <= s4_earlier;
      res.year_overflow <= overflow_next;
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the next-day date unit with packed yyyymmdd date pairs; each result is
// checked against its typed row or a calendar predictor. A short directed table
// covers the field extremes, leap and century years, month and year ends, the
// year overflow and malformed dates. Random dates follow, mostly well-formed
// with many month ends, with raw and malformed values mixed in. Both sides
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned LAST_DATE      = 99991231;
  localparam int unsigned FIRST_OVERFLOW = 100000000;
  localparam int unsigned FEBRUARY       = 2;
  localparam int unsigned DECEMBER       = 12;
  localparam int unsigned MARCH_INDEX    = 2;
  localparam int unsigned RANDOM_ITEMS   = 1250;
  localparam int unsigned HOLD_AFTER     = 300;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef struct packed {
    gdnd_pkg::request_t req;
    logic               typed;
    gdnd_pkg::result_t  want;
  } date_row_t;

  typedef struct packed {
    gdnd_pkg::request_t req;
    gdnd_pkg::result_t  want;
  } awaited_day_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gdnd_request_if request_ch ();
  gdnd_result_if  result_ch ();

  gregorian_date_next_day DUT (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  date_row_t    directed_rows[$];
  awaited_day_t awaited_days[$];
  int unsigned  fail_count   = 0;
  int unsigned  results_seen = 0;
  int unsigned  cycle_count  = 0;
  bit           holding      = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic bit leap_of(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_days(int unsigned m, bit leap);
    case (m)
      4, 6, 9, 11:               return 30;
      1, 3, 5, 7, 8, 10, 12:     return 31;
      FEBRUARY:                  return leap ? 29 : 28;
      default:                   return 28;
    endcase
  endfunction

  function automatic gdnd_pkg::result_t next_day_of(gdnd_pkg::request_t r);
    int unsigned       d, y, m, dd, dim, idx, prior, ny, nm, nd, nxt;
    bit                leap, ovf;
    gdnd_pkg::result_t res;
    d    = r.date;
    y    = d / 10000;
    m    = (d % 10000) / 100;
    dd   = d % 100;
    leap = leap_of(y);
    dim  = month_days(m, leap);
    idx  = (m == 0) ? 0 : (m > DECEMBER) ? DECEMBER : m - 1;
    prior = 0;
    for (int unsigned k = 1; k <= idx; k++) prior += month_days(k, 1'b0);
    if (leap && idx >= MARCH_INDEX) prior += 1;
    if (dd == dim) begin
      nd = 1;
      nm = (m == DECEMBER) ? 1 : m + 1;
      ny = (m == DECEMBER) ? y + 1 : y;
    end else begin
      nd = dd + 1;
      nm = m;
      ny = y;
    end
    nxt = ny * 10000 + nm * 100 + nd;
    ovf = nxt >= FIRST_OVERFLOW;
    if (ovf) nxt = LAST_DATE;
    res.next_date     = gdnd_pkg::DATE_W'(nxt);
    res.year          = gdnd_pkg::YEAR_W'(y);
    res.month         = gdnd_pkg::MONTH_W'(m);
    res.day_of_month  = gdnd_pkg::DAY_W'(dd);
    res.day_of_year   = gdnd_pkg::DOY_W'(prior + dd);
    res.days_in_month = gdnd_pkg::DIM_W'(dim);
    res.leap_year     = leap;
    res.is_earlier    = r.date < r.other_date;
    res.year_overflow = ovf;
    return res;
  endfunction

  function automatic date_row_t typed_row(int unsigned d, int unsigned o,
                                          gdnd_pkg::result_t want);
    date_row_t row;
    row.req.date       = gdnd_pkg::DATE_W'(d);
    row.req.other_date = gdnd_pkg::DATE_W'(o);
    row.typed          = 1'b1;
    row.want           = want;
    return row;
  endfunction

  function automatic date_row_t plain_row(int unsigned d, int unsigned o);
    date_row_t row;
    row       = typed_row(d, o, '0);
    row.typed = 1'b0;
    return row;
  endfunction

  function automatic int unsigned draw_idle(inout bit streaming);
    if ($urandom_range(0, 29) == 0) streaming = !streaming;
    return streaming ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic int unsigned random_date();
    int unsigned y, m, dd, dim, v, kind;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      case ($urandom_range(0, 9))
        0:       y = $urandom_range(9998, 9999);
        1:       y = 100 * $urandom_range(16, 99);
        default: y = $urandom_range(1583, 9999);
      endcase
      m   = $urandom_range(1, 12);
      dim = month_days(m, leap_of(y));
      dd  = ($urandom_range(0, 9) < 4) ? dim : $urandom_range(1, dim);
      v   = y * 10000 + m * 100 + dd;
    end else if (kind < 75) begin
      v = $urandom_range(0, LAST_DATE);
    end else if (kind < 92) begin
      y = $urandom_range(0, 9999);
      case ($urandom_range(0, 2))
        0:       m = 0;
        1:       m = $urandom_range(13, 99);
        default: m = $urandom_range(1, 12);
      endcase
      dim = month_days(m, leap_of(y));
      case ($urandom_range(0, 3))
        0:       dd = 0;
        1:       dd = $urandom_range(dim + 1, 99);
        2:       dd = dim;
        default: dd = $urandom_range(1, 31);
      endcase
      v = y * 10000 + m * 100 + dd;
      if (v > LAST_DATE) v = LAST_DATE;
    end else begin
      v = LAST_DATE - $urandom_range(0, 2);
    end
    return v;
  endfunction

  function automatic string fields_of(gdnd_pkg::result_t r);
    return $sformatf("next=%0d y=%0d m=%0d d=%0d doy=%0d dim=%0d leap=%0b early=%0b ovf=%0b",
                     r.next_date, r.year, r.month, r.day_of_month, r.day_of_year,
                     r.days_in_month, r.leap_year, r.is_earlier, r.year_overflow);
  endfunction

  task automatic send_dates(date_row_t row, inout bit streaming);
    int unsigned  gap;
    awaited_day_t entry;
    gap = holding ? 0 : draw_idle(streaming);
    @(negedge clk);
    if (gap > 0) begin
      request_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    request_ch.valid   = 1'b1;
    request_ch.payload = row.req;
    do @(posedge clk); while (!request_ch.ready);
    entry.req  = row.req;
    entry.want = row.typed ? row.want : next_day_of(row.req);
    awaited_days.push_back(entry);
  endtask

  task automatic check_result(gdnd_pkg::result_t got);
    awaited_day_t entry;
    if (awaited_days.size() == 0) begin
      if (fail_count < REPORT_LIMIT) $display("unexpected result: %s", fields_of(got));
      fail_count++;
    end else begin
      entry = awaited_days.pop_front();
      if (got.next_date !== entry.want.next_date || got.year !== entry.want.year ||
          got.month !== entry.want.month || got.day_of_month !== entry.want.day_of_month ||
          got.day_of_year !== entry.want.day_of_year ||
          got.days_in_month !== entry.want.days_in_month ||
          got.leap_year !== entry.want.leap_year || got.is_earlier !== entry.want.is_earlier ||
          got.year_overflow !== entry.want.year_overflow) begin
        if (fail_count < REPORT_LIMIT) begin
          $display("mismatch for date %0d other %0d", entry.req.date, entry.req.other_date);
          $display("  expected %s", fields_of(entry.want));
          $display("  actual   %s", fields_of(got));
        end
        fail_count++;
      end
    end
  endtask

  // result side: random stalls, one long hold-off
  initial begin
    int unsigned stall;
    bit          streaming;
    streaming = 1'b0;
    result_ch.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (results_seen == HOLD_AFTER) begin
        holding = 1'b1;
        stall   = HOLD_CYCLES;
      end else begin
        holding = 1'b0;
        stall   = draw_idle(streaming);
      end
      if (stall > 0) begin
        result_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      check_result(result_ch.payload);
      results_seen++;
      @(negedge clk);
    end
  end

  // request side: directed table, then random dates
  initial begin
    bit          streaming;
    int unsigned d, o;
    streaming          = 1'b0;
    request_ch.valid   = 1'b0;
    request_ch.payload = '0;

    directed_rows.push_back(typed_row(LAST_DATE, 0,
      '{27'd99991231, 14'd9999, 4'd12, 5'd31, 9'd365, 5'd31, 1'b0, 1'b0, 1'b1}));
    directed_rows.push_back(typed_row(0, LAST_DATE,
      '{27'd1, 14'd0, 4'd0, 5'd0, 9'd0, 5'd28, 1'b1, 1'b1, 1'b0}));
    directed_rows.push_back(typed_row(20240229, 20240229,
      '{27'd20240301, 14'd2024, 4'd2, 5'd29, 9'd60, 5'd29, 1'b1, 1'b0, 1'b0}));
    directed_rows.push_back(typed_row(20001231, 20010101,
      '{27'd20010101, 14'd2000, 4'd12, 5'd31, 9'd366, 5'd31, 1'b1, 1'b1, 1'b0}));
    directed_rows.push_back(typed_row(19000228, 0,
      '{27'd19000301, 14'd1900, 4'd2, 5'd28, 9'd59, 5'd28, 1'b0, 1'b0, 1'b0}));
    directed_rows.push_back(typed_row(20249999, 0,
      '{27'd20250000, 14'd2024, 4'd3, 5'd3, 9'd465, 5'd28, 1'b1, 1'b0, 1'b0}));
    directed_rows.push_back(typed_row(99981231, 99981231,
      '{27'd99990101, 14'd9998, 4'd12, 5'd31, 9'd365, 5'd31, 1'b0, 1'b0, 1'b0}));
    directed_rows.push_back(plain_row(20230228, 20230301));
    directed_rows.push_back(plain_row(20240228, 20240227));
    directed_rows.push_back(plain_row(20230131, 20230131));
    directed_rows.push_back(plain_row(20230430, 99991231));
    directed_rows.push_back(plain_row(20230431, 0));
    directed_rows.push_back(plain_row(20231315, 20231316));
    directed_rows.push_back(plain_row(20230005, 20230004));
    directed_rows.push_back(plain_row(20230100, 20230101));
    directed_rows.push_back(plain_row(20230028, 1));
    directed_rows.push_back(plain_row(99991130, 99991201));
    directed_rows.push_back(plain_row(99991230, 99991231));
    directed_rows.push_back(plain_row(16000229, 16000301));
    directed_rows.push_back(plain_row(21000228, 21000228));
    directed_rows.push_back(plain_row(15830101, 67108863));
    directed_rows.push_back(plain_row(67108864, 67108863));
    directed_rows.push_back(plain_row(98761130, 12345678));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) send_dates(directed_rows[i], streaming);

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      d = random_date();
      case ($urandom_range(0, 9))
        0, 1, 2: o = d;
        3, 4:    o = (d < LAST_DATE) ? d + 1 : d;
        5, 6:    o = (d > 0) ? d - 1 : d;
        default: o = $urandom_range(0, LAST_DATE);
      endcase
      send_dates(plain_row(d, o), streaming);
    end

    @(negedge clk);
    request_ch.valid = 1'b0;
    while (awaited_days.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited_days.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ gregorian_date_next_day.f @@
design/gdnd_pkg.sv
design/gdnd_request_if.sv
design/gdnd_result_if.sv
design/gdnd_repack.sv
design/gregorian_date_next_day.sv
tb/sv/testbench.sv
